// File: src/lps_pkg.sv
package lps_pkg;

  localparam int MaxPoints  = 64;
  localparam int CoordWidth = 32;
  localparam int IndexWidth = 6;

  typedef struct packed {
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        final_point;
  } in_word_t;

  typedef struct packed {
    logic [5:0] point_index;
    logic       last_rank;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

// File: src/lexicographic_point_sorter_top.sv
// Lexicographic point sorter. Points arrive one word at a time; each is placed into a
// sorted key memory by a sweep from the top entry down. Every held entry that sorts after
// the new point is read and then written back one place up, and in_ready stays low until
// the point is placed. On the word marked final_point, the load indices of the held
// points stream out in ascending (x, y, z) order over the first dims coordinates, each
// word read from the index memory and then registered onto out_data, with last_rank set
// on the final one; the next word is read only once out_data is empty or being taken.
// Ties keep load order. A point arriving while MAX_POINTS points are held is dropped.
// A dims setting (cfg_data) of 0 acts as 1.
module lexicographic_point_sorter_top #(
  parameter int MAX_POINTS  = lps_pkg::MaxPoints,
  parameter int COORD_WIDTH = lps_pkg::CoordWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  lps_pkg::in_word_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output lps_pkg::out_word_t out_data,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         cfg_data,
  input  logic               cfg_valid,
  output logic               cfg_ready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = 3 * COORD_WIDTH;

  lps_pkg::state_t state, state_next;

  logic [1:0]    dims;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] ptr, ptr_next;
  logic          fin, fin_next;

  logic signed [COORD_WIDTH-1:0] kx, ky, kz;
  logic [1:0] kdims;

  logic [KW-1:0] key_mem [MAX_POINTS];
  logic [AW-1:0] idx_mem [MAX_POINTS];
  logic [KW-1:0] rd_key;
  logic [AW-1:0] rd_idx;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [KW-1:0] wr_key;
  logic [AW-1:0] wr_idx;

  logic          o_valid, o_valid_next;
  lps_pkg::out_word_t o_data, o_data_next;

  logic signed [COORD_WIDTH-1:0] ex, ey, ez;
  logic gt;
  logic at_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == lps_pkg::ST_LOAD);
  assign out_valid = o_valid;
  assign out_data  = o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      dims <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_idx <= idx_mem[rd_addr];
    end
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      idx_mem[wr_addr] <= wr_idx;
    end
  end

  // Latch the incoming key with the dimension setting at arrival.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kx    <= in_data.coord_x[COORD_WIDTH-1:0];
      ky    <= in_data.coord_y[COORD_WIDTH-1:0];
      kz    <= in_data.coord_z[COORD_WIDTH-1:0];
      kdims <= (dims == 2'd0) ? 2'd1 : dims;
    end
  end

  assign ex = rd_key[KW-1 -: COORD_WIDTH];
  assign ey = rd_key[2*COORD_WIDTH-1 -: COORD_WIDTH];
  assign ez = rd_key[COORD_WIDTH-1:0];

  assign at_last = (CW'(ptr) == count - CW'(1));

  always_comb begin
    if (ex != kx) begin
      gt = ex > kx;
    end else if (kdims == 2'd1) begin
      gt = 1'b0;
    end else if (ey != ky) begin
      gt = ey > ky;
    end else if (kdims == 2'd2) begin
      gt = 1'b0;
    end else begin
      gt = ez > kz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lps_pkg::ST_LOAD;
      count   <= '0;
      ptr     <= '0;
      fin     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ptr     <= ptr_next;
      fin     <= fin_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    o_data <= o_data_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    fin_next     = fin;
    o_valid_next = o_valid && !out_ready;
    o_data_next  = o_data;
    rd_en        = 1'b0;
    rd_addr      = ptr;
    wr_en        = 1'b0;
    wr_addr      = ptr;
    wr_key       = {kx, ky, kz};
    wr_idx       = count[AW-1:0];
    case (state)
      lps_pkg::ST_LOAD: begin
        if (in_valid) begin
          fin_next = in_data.final_point;
          if (count == CW'(MAX_POINTS)) begin
            if (in_data.final_point) begin
              ptr_next   = '0;
              state_next = lps_pkg::ST_EMIT_RD;
            end
          end else if (count == '0) begin
            state_next = lps_pkg::ST_PLACE;
          end else begin
            ptr_next   = AW'(count - CW'(1));
            state_next = lps_pkg::ST_READ;
          end
        end
      end
      lps_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = lps_pkg::ST_SHIFT;
      end
      lps_pkg::ST_SHIFT: begin
        // Entry at ptr was read last cycle: move it up, or drop the key above it.
        wr_en   = 1'b1;
        wr_addr = ptr + AW'(1);
        if (gt) begin
          wr_key = rd_key;
          wr_idx = rd_idx;
          if (ptr == '0) begin
            state_next = lps_pkg::ST_PLACE;
          end else begin
            ptr_next   = ptr - AW'(1);
            state_next = lps_pkg::ST_READ;
          end
        end else begin
          count_next = count + CW'(1);
          if (fin) begin
            ptr_next   = '0;
            state_next = lps_pkg::ST_EMIT_RD;
          end else begin
            state_next = lps_pkg::ST_LOAD;
          end
        end
      end
      lps_pkg::ST_PLACE: begin
        // Every held entry sorts after the key, or the set is empty: write it at 0.
        wr_en      = 1'b1;
        wr_addr    = '0;
        count_next = count + CW'(1);
        if (fin) begin
          ptr_next   = '0;
          state_next = lps_pkg::ST_EMIT_RD;
        end else begin
          state_next = lps_pkg::ST_LOAD;
        end
      end
      lps_pkg::ST_EMIT_RD: begin
        if (count == '0) begin
          state_next = lps_pkg::ST_LOAD;
        end else if (!o_valid || out_ready) begin
          rd_en      = 1'b1;
          state_next = lps_pkg::ST_EMIT;
        end
      end
      lps_pkg::ST_EMIT: begin
        o_valid_next            = 1'b1;
        o_data_next.point_index = lps_pkg::IndexWidth'(rd_idx);
        o_data_next.last_rank   = at_last;
        if (at_last) begin
          count_next = '0;
          state_next = lps_pkg::ST_LOAD;
        end else begin
          ptr_next   = ptr + AW'(1);
          state_next = lps_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = lps_pkg::ST_LOAD;
    endcase
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == lps_pkg::ST_LOAD) else $error("ready while busy");

endmodule
